/* hdl/assert_macros.svh */
// Assertion macros shared by the pixel fetch RTL.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset
`define BWPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition must never be seen outside reset
`define BWPF_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BWPF_ASSERT(lbl, prop, msg)
`define BWPF_NEVER(lbl, cond, msg)
`endif
`endif

/* hdl/bwpf_pkg.sv */
// Package for the background/window pixel fetch: constants, payload types,
// register indexes, state encoding and the shade-to-gray lookup. No dependencies.
package bwpf_pkg;

  // Video memory geometry: two byte-wide banks, even and odd addresses
  localparam int VRAM_BYTES = 8192;
  localparam int VRAM_AW    = $clog2(VRAM_BYTES);
  localparam int BANK_DEPTH = VRAM_BYTES / 2;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  localparam int SCREEN_WIDTH = 160;
  localparam logic [8:0] SCREEN_LIMIT = 9'(SCREEN_WIDTH);

  localparam logic [VRAM_AW-1:0] MAP_LOW_BASE = VRAM_AW'(16'h1800);
  localparam int SIGNED_TILE_BASE = 16'h0800;
  localparam logic [BANK_AW-1:0] SIGNED_PAIR_BASE = BANK_AW'(SIGNED_TILE_BASE / 2);
  localparam logic [7:0] SIGNED_TILE_BIAS = 8'h80;
  localparam logic [7:0] WIN_X_OFFSET = 8'd7;

  // Control register bit positions
  localparam int LCDC_BG_EN    = 0;
  localparam int LCDC_BG_MAP   = 3;
  localparam int LCDC_UNSIGNED = 4;
  localparam int LCDC_WIN_EN   = 5;
  localparam int LCDC_WIN_MAP  = 6;

  localparam logic [7:0] GRAY_SHADE0 = 8'hFF;
  localparam logic [7:0] GRAY_SHADE1 = 8'hCC;
  localparam logic [7:0] GRAY_SHADE2 = 8'h77;
  localparam logic [7:0] GRAY_SHADE3 = 8'h00;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_RENDER = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    CFG_SCROLL_Y   = 3'd0,
    CFG_SCROLL_X   = 3'd1,
    CFG_WINDOW_Y   = 3'd2,
    CFG_WINDOW_X   = 3'd3,
    CFG_BG_PALETTE = 3'd4,
    CFG_LCD_CTRL   = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TILE,
    ST_PIX
  } state_e;

  typedef struct packed {
    logic               action;
    logic [VRAM_AW-1:0] vram_offset;
    logic [7:0]         write_data;
    logic [7:0]         column;
    logic [7:0]         line;
  } req_t;

  typedef struct packed {
    logic [7:0] out_column;
    logic [7:0] out_line;
    logic [1:0] shade;
    logic [7:0] gray;
  } res_t;

  typedef struct packed {
    logic [2:0] index;
    logic [7:0] value;
  } cfg_t;

  function automatic logic [7:0] gray_of(input logic [1:0] shade);
    logic [7:0] g;
    unique case (shade)
      2'd0:    g = GRAY_SHADE0;
      2'd1:    g = GRAY_SHADE1;
      2'd2:    g = GRAY_SHADE2;
      default: g = GRAY_SHADE3;
    endcase
    return g;
  endfunction

endpackage

/* hdl/bwpf_ifs.sv */
// Valid/ready channels of the pixel fetch: render/write requests, results
// and configuration writes. Depends on bwpf_pkg.
interface bwpf_req_if;
  import bwpf_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bwpf_res_if;
  import bwpf_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bwpf_cfg_if;
  import bwpf_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/background_window_pixel_fetch.sv */
// Background/window pixel fetch. A render request with the background enabled and
// its column on screen gives its result through the map read on acceptance, the tile
// pair read and the palette into the result register. No new request is taken until
// that register is loaded, set by the two dependent reads of the banked video memory,
// and longer while a result waits on the output. Reset is asynchronous; afterwards a
// clearing pass zeroes both banks one row a cycle, during which no request is accepted
// (config still is). Depends on bwpf_pkg, bwpf_ifs and assert_macros.svh.
`include "assert_macros.svh"

module background_window_pixel_fetch (
  input  logic       clk_i,
  input  logic       rst_ni,
  bwpf_req_if.sink   pix_req_i,
  bwpf_res_if.source pix_res_o,
  bwpf_cfg_if.sink   cfg_i
);
  import bwpf_pkg::*;

  state_e state_q, state_d;

  logic [7:0] scroll_y_q, scroll_x_q, window_y_q, window_x_q, bg_palette_q, lcd_ctrl_q;

  logic [BANK_AW-1:0] clr_idx_q;
  logic [7:0]         mem_even [BANK_DEPTH];
  logic [7:0]         mem_odd  [BANK_DEPTH];
  logic [7:0]         rd_even_q, rd_odd_q;

  logic [2:0] y_fine_q, x_fine_q;
  logic       map_sel_q;
  logic [7:0] column_q, line_q;

  logic       res_valid_q;
  res_t       res_q;

  req_t               req;
  logic               req_acc, render_go, wr_go, col_ok;
  logic               win;
  logic [7:0]         wx, y_pos, x_pos;
  logic [VRAM_AW-1:0] map_addr;
  logic [7:0]         tile_num;
  logic [BANK_AW-1:0] tile_idx, rd_idx, wr_idx;
  logic [7:0]         wr_data;
  logic               we_even, we_odd, rd_en;
  logic               in_ready, rd_map, rd_tile, load_res, clearing, out_free;
  logic [2:0]         bit_sel;
  logic [1:0]         pal_idx, shade;

  // Configuration registers: always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_y_q   <= '0;
      scroll_x_q   <= '0;
      window_y_q   <= '0;
      window_x_q   <= '0;
      bg_palette_q <= '0;
      lcd_ctrl_q   <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.data.index)
        CFG_SCROLL_Y:   scroll_y_q   <= cfg_i.data.value;
        CFG_SCROLL_X:   scroll_x_q   <= cfg_i.data.value;
        CFG_WINDOW_Y:   window_y_q   <= cfg_i.data.value;
        CFG_WINDOW_X:   window_x_q   <= cfg_i.data.value;
        CFG_BG_PALETTE: bg_palette_q <= cfg_i.data.value;
        CFG_LCD_CTRL:   lcd_ctrl_q   <= cfg_i.data.value;
        default: ;
      endcase
    end
  end

  // Request decode
  assign req       = pix_req_i.data;
  assign req_acc   = pix_req_i.valid && in_ready;
  assign col_ok    = {1'b0, req.column} < SCREEN_LIMIT;
  assign render_go = req_acc && (req.action == ACT_RENDER) && lcd_ctrl_q[LCDC_BG_EN] && col_ok;
  assign wr_go     = req_acc && (req.action == ACT_WRITE);
  assign out_free  = !res_valid_q || pix_res_o.ready;

  // Map coordinates and map byte address
  always_comb begin
    win   = lcd_ctrl_q[LCDC_WIN_EN] && (window_y_q <= req.line);
    wx    = window_x_q - WIN_X_OFFSET;
    y_pos = win ? (req.line - window_y_q) : (scroll_y_q + req.line);
    x_pos = (win && (req.column >= wx)) ? (req.column - wx) : (scroll_x_q + req.column);
    map_addr = MAP_LOW_BASE
             + {2'b00, (win ? lcd_ctrl_q[LCDC_WIN_MAP] : lcd_ctrl_q[LCDC_BG_MAP]),
                y_pos[7:3], x_pos[7:3]};
  end

  // Tile row pair: low plane even byte, high plane odd byte of the same row
  always_comb begin
    tile_num = map_sel_q ? rd_odd_q : rd_even_q;
    if (lcd_ctrl_q[LCDC_UNSIGNED]) begin
      tile_idx = {1'b0, tile_num, y_fine_q};
    end else begin
      tile_idx = SIGNED_PAIR_BASE + {1'b0, tile_num ^ SIGNED_TILE_BIAS, y_fine_q};
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_idx_q == '1) state_d = ST_IDLE;
      ST_IDLE:  if (render_go) state_d = ST_TILE;
      ST_TILE:  state_d = ST_PIX;
      ST_PIX:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    clearing = 1'b0;
    rd_map   = 1'b0;
    rd_tile  = 1'b0;
    load_res = 1'b0;
    unique case (state_q)
      ST_CLEAR: clearing = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        rd_map   = render_go;
      end
      ST_TILE:  rd_tile  = 1'b1;
      ST_PIX:   load_res = out_free;
      default: ;
    endcase
  end

  assign pix_req_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (clearing) clr_idx_q <= clr_idx_q + 1'b1;
    end
  end

  // Memory port selection
  assign we_even = clearing || (wr_go && !req.vram_offset[0]);
  assign we_odd  = clearing || (wr_go && req.vram_offset[0]);
  assign wr_idx  = clearing ? clr_idx_q : req.vram_offset[VRAM_AW-1:1];
  assign wr_data = clearing ? 8'h00 : req.write_data;
  assign rd_en   = rd_map || rd_tile;
  assign rd_idx  = rd_map ? map_addr[VRAM_AW-1:1] : tile_idx;

  // Even-address bank
  always_ff @(posedge clk_i) begin
    if (we_even) mem_even[wr_idx] <= wr_data;
    if (rd_en)   rd_even_q <= mem_even[rd_idx];
  end

  // Odd-address bank
  always_ff @(posedge clk_i) begin
    if (we_odd) mem_odd[wr_idx] <= wr_data;
    if (rd_en)  rd_odd_q <= mem_odd[rd_idx];
  end

  // Hold the pixel context for the later stages
  always_ff @(posedge clk_i) begin
    if (rd_map) begin
      y_fine_q  <= y_pos[2:0];
      x_fine_q  <= x_pos[2:0];
      map_sel_q <= map_addr[0];
      column_q  <= req.column;
      line_q    <= req.line;
    end
  end

  // Colour id from the two planes, then palette
  assign bit_sel = ~x_fine_q;
  assign pal_idx = {rd_odd_q[bit_sel], rd_even_q[bit_sel]};
  assign shade   = bg_palette_q[{pal_idx, 1'b0} +: 2];

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (load_res) begin
      res_valid_q <= 1'b1;
    end else if (pix_res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      res_q.out_column <= column_q;
      res_q.out_line   <= line_q;
      res_q.shade      <= shade;
      res_q.gray       <= gray_of(shade);
    end
  end

  assign pix_res_o.valid = res_valid_q;
  assign pix_res_o.data  = res_q;

  `BWPF_ASSERT(a_tile_after_idle, (state_q == ST_TILE) |-> ($past(state_q) == ST_IDLE), "tile read not preceded by map read")
  `BWPF_ASSERT(a_render_to_tile, render_go |=> (state_q == ST_TILE), "accepted render did not reach tile stage")
  `BWPF_ASSERT(a_result_from_pix, $rose(res_valid_q) |-> ($past(state_q) == ST_PIX), "result appeared outside palette stage")
  `BWPF_NEVER(a_no_write_in_flight, ((state_q == ST_TILE) || (state_q == ST_PIX)) && (we_even || we_odd), "memory written during a render")

endmodule
